// File: rtl/assert_macros.svh
// assertion macros shared by the front end, queue and back end rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, ignored while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/wsf_pkg.sv
// types and constants of the 3x3 window smoothing filter
`default_nettype none

package wsf_pkg;

    // field widths
    localparam int PIX_W     = 8;
    localparam int WGT_W     = 8;
    localparam int KROW_W    = 24;
    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 12;
    localparam int RES_W     = 16;
    localparam int CFG_IDX_W = 3;

    // build-time defaults
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int KERNEL_SIZE   = 3;

    // divide by kernel area as multiply by reciprocal and shift
    localparam int DIV_N     = KERNEL_SIZE * KERNEL_SIZE;
    localparam int PROD_W    = PIX_W + WGT_W;
    localparam int DIV_SHIFT = 19;
    localparam int DIV_MUL   = ((1 << DIV_SHIFT) + DIV_N - 1) / DIV_N;
    localparam int QUO_W     = 13;
    localparam int RSUM_W    = 15;

    // item queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // reset values of the registers
    localparam logic [IMG_W_W-1:0] IMG_W_RST = IMG_W_W'(1024);
    localparam logic [IMG_H_W-1:0] IMG_H_RST = IMG_H_W'(3);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KROW_TOP = 3'd0,
        CFG_KROW_MID = 3'd1,
        CFG_KROW_BOT = 3'd2,
        CFG_WIDTH    = 3'd3,
        CFG_HEIGHT   = 3'd4
    } t_cfg_idx;

    // window and weights, [row][column], column 0 is left
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] t_window;
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][WGT_W-1:0] t_kernel;

    // one queued item: a full window and its end-of-image flag
    typedef struct packed {
        t_window pix;
        logic    last;
    } t_win_item;

    // queue status seen by the back end
    typedef struct packed {
        logic    empty;
        logic [Q_CW-1:0] cnt;
    } t_q_stat;

endpackage

`default_nettype wire

// File: rtl/wsf_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module wsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/wsf_front.sv
// front end: raster counters, line stores and the 3x3 window
`default_nettype none

`include "assert_macros.svh"

module wsf_front #(
    parameter int MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [wsf_pkg::PIX_W-1:0]     i_pixel,
    output logic                               o_stall,
    input  wire logic [wsf_pkg::IMG_W_W-1:0]   i_width,
    input  wire logic [wsf_pkg::IMG_H_W-1:0]   i_height,
    input  wire wsf_pkg::t_q_stat              i_q_stat,
    output logic                               o_push,
    output wsf_pkg::t_win_item                 o_push_item
);

    import wsf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int EWB = $clog2(MAX_WIDTH + 1);
    localparam int LW  = ((EWB > IMG_W_W) ? EWB : IMG_W_W) + 1;
    localparam int HW  = IMG_H_W + 1;

    logic              r_run;
    logic [CW-1:0]     r_col, n_col;
    logic [IMG_H_W-1:0] r_row, n_row;
    logic              acc;

    logic [LW-1:0]     cfg_w, w_eff, col_ext, c_use;
    logic [HW-1:0]     h_eff, row_ext;
    logic              item_out, item_last;

    logic              r_s1_valid, r_s1_out, r_s1_last;
    logic [CW-1:0]     r_s1_col;
    logic [PIX_W-1:0]  r_s1_px;
    logic [PIX_W-1:0]  up_q, lo_q;
    t_window           r_win, n_win;

    // room check: queue entries plus the item in the window stage
    assign o_stall = !r_run ||
                     ((i_q_stat.cnt + Q_CW'(r_s1_valid)) >= Q_CW'(Q_DEPTH));
    assign acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    // effective image size and clamped column
    always_comb begin
        cfg_w   = LW'(i_width);
        w_eff   = cfg_w;
        if (cfg_w < LW'(KERNEL_SIZE)) begin
            w_eff = LW'(KERNEL_SIZE);
        end else if (cfg_w > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end
        h_eff   = (i_height < IMG_H_W'(KERNEL_SIZE)) ? HW'(KERNEL_SIZE) : HW'(i_height);
        col_ext = LW'(r_col);
        c_use   = (col_ext >= w_eff) ? (w_eff - LW'(1)) : col_ext;
        row_ext = HW'(r_row);
        item_out  = (row_ext >= HW'(KERNEL_SIZE - 1)) && (c_use >= LW'(KERNEL_SIZE - 1));
        item_last = ((row_ext + HW'(1)) >= h_eff) && ((c_use + LW'(1)) >= w_eff);
    end

    // raster counters
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if ((col_ext + LW'(1)) >= w_eff) begin
            n_col = '0;
            n_row = ((row_ext + HW'(1)) >= h_eff) ? '0 : (r_row + IMG_H_W'(1));
        end else begin
            n_col = CW'(col_ext + LW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line stores, read at accept, written back in the following cycle
    wsf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (lo_q),
        .i_re    (acc),
        .i_raddr (c_use[CW-1:0]),
        .o_rdata (up_q)
    );

    wsf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_lower (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_px),
        .i_re    (acc),
        .i_raddr (c_use[CW-1:0]),
        .o_rdata (lo_q)
    );

    // window stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
        end
    end

    // window stage payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_col  <= c_use[CW-1:0];
            r_s1_px   <= i_pixel;
            r_s1_out  <= item_out;
            r_s1_last <= item_last;
        end
    end

    // shift the window left and insert the new column
    always_comb begin
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
                n_win[j][i] = r_win[j][i+1];
            end
        end
        n_win[0][KERNEL_SIZE-1] = up_q;
        n_win[1][KERNEL_SIZE-1] = lo_q;
        n_win[2][KERNEL_SIZE-1] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    // interior pixels go to the queue
    assign o_push           = r_s1_valid && r_s1_out;
    assign o_push_item.pix  = n_win;
    assign o_push_item.last = r_s1_last;

    `ASSERT_NEXT(a_acc_to_win, i_clk, i_rst_n, acc, r_s1_valid)
    `ASSERT_IMPL(a_push_room, i_clk, i_rst_n, o_push, i_q_stat.cnt < Q_CW'(Q_DEPTH))

endmodule

`default_nettype wire

// File: rtl/wsf_fifo.sv
// short item queue between the front and back ends
`default_nettype none

`include "assert_macros.svh"

module wsf_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire wsf_pkg::t_win_item i_item,
    input  wire logic               i_pop,
    output wsf_pkg::t_win_item      o_item,
    output wsf_pkg::t_q_stat        o_stat
);

    import wsf_pkg::*;

    t_win_item          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wp, r_rp;
    logic [Q_CW-1:0]    r_cnt;
    logic               pop_ok;

    assign pop_ok       = i_pop && (r_cnt != '0);
    assign o_item       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.cnt   = r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (pop_ok) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_cnt <= r_cnt + Q_CW'(i_push) - Q_CW'(pop_ok);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, r_cnt < Q_CW'(Q_DEPTH) || pop_ok)
    `ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, i_push && !pop_ok, r_cnt == $past(r_cnt) + 1'b1)

endmodule

`default_nettype wire

// File: rtl/wsf_back.sv
// back end: weighted terms, divide by kernel area, sum, output register
`default_nettype none

`include "assert_macros.svh"

module wsf_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire wsf_pkg::t_win_item          i_item,
    input  wire wsf_pkg::t_q_stat            i_q_stat,
    output logic                             o_pop,
    input  wire wsf_pkg::t_kernel            i_kernel,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [wsf_pkg::RES_W-1:0]        o_smoothed,
    output logic                             o_last_result
);

    import wsf_pkg::*;

    localparam int MUL_W = PROD_W + PROD_W;

    logic en;
    logic r_v0, r_v1, r_v2;
    logic r_l0, r_l1, r_l2;
    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PROD_W-1:0] r_prod;
    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][QUO_W-1:0]  r_quo;
    logic [KERNEL_SIZE-1:0][RSUM_W-1:0]                  r_rsum;
    logic [KERNEL_SIZE-1:0][RSUM_W-1:0]                  rsum;
    logic [MUL_W-1:0]                                    rec [KERNEL_SIZE][KERNEL_SIZE];
    logic [RES_W-1:0]                                    total;

    // whole pipe moves unless a finished result is held up
    assign en    = !o_valid || !i_stall;
    assign o_pop = en && !i_q_stat.empty;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_v0    <= !i_q_stat.empty;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
    end

    // reciprocal multiply for truncated divide
    always_comb begin
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                rec[j][i] = MUL_W'(r_prod[j][i]) * MUL_W'(DIV_MUL);
            end
        end
    end

    // row sums and total
    always_comb begin
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            rsum[j] = RSUM_W'(r_quo[j][0]) + RSUM_W'(r_quo[j][1]) + RSUM_W'(r_quo[j][2]);
        end
        total = RES_W'(r_rsum[0]) + RES_W'(r_rsum[1]) + RES_W'(r_rsum[2]);
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                for (int i = 0; i < KERNEL_SIZE; i++) begin
                    r_prod[j][i] <= PROD_W'(i_item.pix[j][i]) * PROD_W'(i_kernel[j][i]);
                    r_quo[j][i]  <= rec[j][i][DIV_SHIFT +: QUO_W];
                end
            end
            r_rsum        <= rsum;
            o_smoothed    <= total;
            r_l0          <= i_item.last;
            r_l1          <= r_l0;
            r_l2          <= r_l1;
            o_last_result <= r_l2;
        end
    end

    `ASSERT_NEXT(a_sum_to_out, i_clk, i_rst_n, r_v2 && en, o_valid)
    `ASSERT_IMPL(a_pop_when_free, i_clk, i_rst_n, o_pop, en && !i_q_stat.empty)

endmodule

`default_nettype wire

// File: rtl/window_smoothing_filter_3x3_unit.sv
// top level of the streaming 3x3 window smoothing filter
//
//  channel   handshake                  payload
//  pixel in  i_valid / o_stall          i_pixel[7:0]
//  result    o_valid / i_stall          o_smoothed[15:0], o_last_result
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index[2:0], i_cfg_data[23:0]
//
// one pixel per clock while results are not stalled; a result passes the line
// store read and window stage, the queue, then the math pipe registers for the
// products, quotients, row sums and total. the cycle after reset release the
// input stalls, then runs free. a stalled result holds the math pipe; the
// 4-entry queue then fills and stalls the input. config is always ready.
`default_nettype none

module window_smoothing_filter_3x3_unit #(
    parameter int MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [wsf_pkg::PIX_W-1:0]       i_pixel,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [wsf_pkg::RES_W-1:0]            o_smoothed,
    output logic                                 o_last_result,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [wsf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [wsf_pkg::KROW_W-1:0]      i_cfg_data
);

    import wsf_pkg::*;

    logic [KERNEL_SIZE-1:0][KROW_W-1:0] r_krow;
    logic [IMG_W_W-1:0]                 r_width;
    logic [IMG_H_W-1:0]                 r_height;
    t_kernel                            kernel;
    logic                               push, pop;
    t_win_item                          push_item, head_item;
    t_q_stat                            q_stat;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_krow   <= '0;
            r_width  <= IMG_W_RST;
            r_height <= IMG_H_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KROW_TOP: r_krow[0] <= i_cfg_data;
                CFG_KROW_MID: r_krow[1] <= i_cfg_data;
                CFG_KROW_BOT: r_krow[2] <= i_cfg_data;
                CFG_WIDTH:    r_width   <= i_cfg_data[IMG_W_W-1:0];
                CFG_HEIGHT:   r_height  <= i_cfg_data[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    // weights, left weight in the low byte of each row
    assign kernel = t_kernel'(r_krow);

    wsf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pixel     (i_pixel),
        .o_stall     (o_stall),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_item (push_item)
    );

    wsf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    wsf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (head_item),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .i_kernel      (kernel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_smoothed    (o_smoothed),
        .o_last_result (o_last_result)
    );

endmodule

`default_nettype wire

// File: test/wsf_result_checker.sv
// result checker for the 3x3 window smoothing filter: tracks the window and compares results
module wsf_result_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_pix_valid,
    input  wire logic                          i_pix_stall,
    input  wire logic [wsf_pkg::PIX_W-1:0]     i_pixel,
    input  wire logic                          i_res_valid,
    input  wire logic                          i_res_stall,
    input  wire logic [wsf_pkg::RES_W-1:0]     i_smoothed,
    input  wire logic                          i_last_result,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [wsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [wsf_pkg::KROW_W-1:0]    i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsf_pkg::*;

    typedef struct {
        logic [RES_W-1:0] smoothed;
        logic             last;
    } t_smoothed_result;

    // expected results in raster order
    t_smoothed_result expected_results[$];
    t_smoothed_result oldest;

    // shadow of the registers and of the window state
    t_kernel                          weights;
    logic [IMG_W_W-1:0]               width_reg;
    logic [IMG_H_W-1:0]               height_reg;
    logic [PIX_W-1:0]                 upper_row [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]                 lower_row [MAX_WIDTH_DEF];
    t_window                          win;
    logic [$clog2(MAX_WIDTH_DEF)-1:0] col_cnt;
    logic [IMG_H_W-1:0]               row_cnt;
    int                               fail_count;

    // shift one pixel into the window and queue the result it completes
    function automatic void take_pixel(input logic [PIX_W-1:0] px);
        int               eff_w;
        int               eff_h;
        int               c;
        logic [PIX_W-1:0] above2;
        logic [PIX_W-1:0] above1;
        int unsigned      total;
        t_smoothed_result res;
        eff_w = (width_reg < 3) ? 3 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
        eff_h = (height_reg < 3) ? 3 : height_reg;
        c = col_cnt;
        if (c >= eff_w) begin
            c = eff_w - 1;
        end
        above2 = upper_row[c];
        above1 = lower_row[c];
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            win[j][0] = win[j][1];
            win[j][1] = win[j][2];
        end
        win[0][2] = above2;
        win[1][2] = above1;
        win[2][2] = px;
        upper_row[c] = above1;
        lower_row[c] = px;

        // interior pixel: each weighted term is truncated on its own
        if (row_cnt >= 2 && c >= 2) begin
            total = 0;
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                for (int i = 0; i < KERNEL_SIZE; i++) begin
                    total += (32'(win[j][i]) * 32'(weights[j][i])) / DIV_N;
                end
            end
            res.smoothed = total[RES_W-1:0];
            res.last = (row_cnt + 1 >= eff_h) && (c + 1 >= eff_w);
            expected_results.push_back(res);
        end

        // raster position, wraps at end of image
        if (col_cnt + 1 >= eff_w) begin
            col_cnt = '0;
            if (row_cnt + 1 >= eff_h) begin
                row_cnt = '0;
            end else begin
                row_cnt = row_cnt + 1'b1;
            end
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            weights = '0;
            width_reg = IMG_W_RST;
            height_reg = IMG_H_RST;
            win = '0;
            col_cnt = '0;
            row_cnt = '0;
            expected_results.delete();
            fail_count = 0;
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KROW_TOP: weights[0] = i_cfg_data;
                    CFG_KROW_MID: weights[1] = i_cfg_data;
                    CFG_KROW_BOT: weights[2] = i_cfg_data;
                    CFG_WIDTH:    width_reg = i_cfg_data[IMG_W_W-1:0];
                    CFG_HEIGHT:   height_reg = i_cfg_data[IMG_H_W-1:0];
                    default: ;
                endcase
            end

            // accepted pixel item
            if (i_pix_valid && !i_pix_stall) begin
                take_pixel(i_pixel);
            end

            // accepted result item against the oldest expectation
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, actual smoothed %0d last %0b",
                             $time, i_smoothed, i_last_result);
                    fail_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_smoothed !== oldest.smoothed) begin
                        $display("%0t: smoothed mismatch, expected %0d, actual %0d",
                                 $time, oldest.smoothed, i_smoothed);
                        fail_count++;
                    end
                    if (i_last_result !== oldest.last) begin
                        $display("%0t: last_result mismatch, expected %0b, actual %0b",
                                 $time, oldest.last, i_last_result);
                        fail_count++;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: test/tb_window_smoothing_filter_3x3_unit.sv
// testbench top for the 3x3 window smoothing filter: image stimulus and verdict
module tb_window_smoothing_filter_3x3_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import wsf_pkg::*;

    localparam int PIXEL_TARGET = 1500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef enum int {PIX_NOISE, PIX_EXTREMES, PIX_RAMP, PIX_SATURATED} t_pixel_style;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [PIX_W-1:0]     i_pixel = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [RES_W-1:0]     o_smoothed;
    logic                 o_last_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [KROW_W-1:0]    i_cfg_data = '0;

    int                   fail_count;
    int                   result_pending;
    int                   cycle_count = 0;
    int                   pixels_sent = 0;
    int                   stall_left = 0;
    bit                   quiet = 1'b0;
    logic [IMG_W_W-1:0]   cur_width = IMG_W_RST;
    logic [IMG_H_W-1:0]   cur_height = IMG_H_RST;

    window_smoothing_filter_3x3_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_smoothed    (o_smoothed),
        .o_last_result (o_last_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    wsf_result_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (i_valid),
        .i_pix_stall   (o_stall),
        .i_pixel       (i_pixel),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_smoothed    (o_smoothed),
        .i_last_result (o_last_result),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (result_pending)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** window_smoothing_filter_3x3_unit: FAILED **");
            $finish;
        end
    end

    // result side stalls in short bursts, about one cycle in ten
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 3) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // one pixel item, with an occasional idle gap before it
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        if (!quiet && $urandom_range(0, 99) < 5) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
    endtask

    // one register write, valid is left high for the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KROW_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // wait until every result is out and the pipe has settled
    task automatic wait_idle();
        i_valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (result_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // new kernel and image size, written only while idle
    task automatic configure(input logic [KROW_W-1:0] top_row, input logic [KROW_W-1:0] mid_row,
                             input logic [KROW_W-1:0] bot_row, input logic [IMG_W_W-1:0] width,
                             input logic [IMG_H_W-1:0] height);
        wait_idle();
        write_reg(CFG_KROW_TOP, top_row);
        write_reg(CFG_KROW_MID, mid_row);
        write_reg(CFG_KROW_BOT, bot_row);
        write_reg(CFG_WIDTH, KROW_W'(width));
        write_reg(CFG_HEIGHT, KROW_W'(height));
        // unused index, must leave everything alone
        write_reg(CFG_IDX_W'(CFG_HEIGHT + 1 + $urandom_range(0, 2)), KROW_W'($urandom));
        i_cfg_valid <= 1'b0;
        cur_width = width;
        cur_height = height;
    endtask

    // weights lean toward zero and full scale
    function automatic logic [KROW_W-1:0] pick_kernel_row();
        logic [KROW_W-1:0] row;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            case ($urandom_range(0, 3))
                0:       row[k*WGT_W +: WGT_W] = '0;
                1:       row[k*WGT_W +: WGT_W] = '1;
                default: row[k*WGT_W +: WGT_W] = WGT_W'($urandom_range(0, 255));
            endcase
        end
        return row;
    endfunction

    // one whole image at the current size
    task automatic send_image(input t_pixel_style style);
        int               eff_w;
        int               eff_h;
        logic [PIX_W-1:0] px;
        eff_w = (cur_width < 3) ? 3 : ((cur_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cur_width);
        eff_h = (cur_height < 3) ? 3 : cur_height;
        for (int k = 0; k < eff_w * eff_h; k++) begin
            case (style)
                PIX_EXTREMES:  px = $urandom_range(0, 1) ? '1 : '0;
                PIX_RAMP:      px = PIX_W'(k * 3 + $urandom_range(0, 3));
                PIX_SATURATED: px = '1;
                default:       px = PIX_W'($urandom_range(0, 255));
            endcase
            send_pixel(px);
            pixels_sent++;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full scale pixels and weights give the largest result
        configure('1, '1, '1, 11'd3, 12'd3);
        send_image(PIX_SATURATED);
        // directed: sizes below the minimum act as 3x3, one weight per row
        configure(24'h0000FF, 24'h00FF00, 24'hFF0000, 11'd0, 12'd0);
        send_image(PIX_EXTREMES);

        // a long image with no idling on either side
        configure(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), 11'd256, 12'd3);
        quiet = 1'b1;
        send_image(PIX_NOISE);
        wait_idle();
        quiet = 1'b0;

        // random images, some streamed back to back with no new settings
        while (pixels_sent < PIXEL_TARGET) begin
            if ($urandom_range(0, 9) >= 3) begin
                logic [IMG_W_W-1:0] width;
                logic [IMG_H_W-1:0] height;
                case ($urandom_range(0, 9))
                    0:       width = IMG_W_W'($urandom_range(0, 2));
                    1:       width = 11'd3;
                    2:       width = IMG_W_W'($urandom_range(40, 120));
                    default: width = IMG_W_W'($urandom_range(4, 24));
                endcase
                case ($urandom_range(0, 9))
                    0:       height = IMG_H_W'($urandom_range(0, 2));
                    1:       height = 12'd3;
                    default: height = IMG_H_W'($urandom_range(4, 10));
                endcase
                configure(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), width, height);
            end
            send_image(t_pixel_style'($urandom_range(0, 2)));
        end

        // tall image, narrowest width through an out of range value
        configure(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), 11'd0, 12'd60);
        send_image(PIX_RAMP);

        wait_idle();
        if (fail_count == 0 && result_pending == 0) begin
            $display("** window_smoothing_filter_3x3_unit: PASSED **");
        end else begin
            $display("** window_smoothing_filter_3x3_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: window_smoothing_filter_3x3_unit.f
+incdir+rtl
rtl/wsf_pkg.sv
rtl/wsf_ram.sv
rtl/wsf_front.sv
rtl/wsf_fifo.sv
rtl/wsf_back.sv
rtl/window_smoothing_filter_3x3_unit.sv
test/wsf_result_checker.sv
test/tb_window_smoothing_filter_3x3_unit.sv
